// File: design/point_rotate_by_sine_table_defines.svh
// Assertion macros for the point rotation block.
// Included by the top level; expects clk and arst_n in scope.
`ifndef POINT_ROTATE_BY_SINE_TABLE_DEFINES_SVH
`define POINT_ROTATE_BY_SINE_TABLE_DEFINES_SVH

// Antecedent true in a cycle implies consequent true in the same cycle.
`define PRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("point rotate check failed");

// Antecedent true in a cycle implies consequent true in the next cycle.
`define PRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("point rotate check failed");

`endif

// File: design/pt_rot_pkg.sv
// Shared types, register indexes and the quarter-wave sine table.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package pt_rot_pkg;

	localparam int unsigned CoordW = 8;
	localparam int unsigned TimeW = 10;
	localparam int unsigned RotW = 10;
	localparam int unsigned PeriodW = 11;
	localparam int unsigned DragW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 11;
	localparam int unsigned AngW = 8;
	localparam int unsigned ProdW = 16;

	localparam logic [CfgIdxW-1:0] CFG_PERIOD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_DRAG = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_REVERSE = 2'd2;

	localparam logic [PeriodW-1:0] PERIOD_RESET = 11'd1024;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [TimeW-1:0] time_t;
	typedef logic signed [RotW-1:0] rot_t;

	// Signed table value held as sign and magnitude.
	typedef struct packed {
		logic       neg;
		logic [7:0] mag;
	} trig_t;

	// First quarter of the sine wave, scaled to 255, for indexes 0 to 64.
	function automatic logic [7:0] sine_quarter(input logic [6:0] idx);
		logic [7:0] v;
		unique case (idx)
			7'd0: v = 8'd0;     7'd1: v = 8'd6;     7'd2: v = 8'd13;    7'd3: v = 8'd19;
			7'd4: v = 8'd25;    7'd5: v = 8'd31;    7'd6: v = 8'd38;    7'd7: v = 8'd44;
			7'd8: v = 8'd50;    7'd9: v = 8'd56;    7'd10: v = 8'd62;   7'd11: v = 8'd68;
			7'd12: v = 8'd74;   7'd13: v = 8'd80;   7'd14: v = 8'd86;   7'd15: v = 8'd92;
			7'd16: v = 8'd98;   7'd17: v = 8'd104;  7'd18: v = 8'd109;  7'd19: v = 8'd115;
			7'd20: v = 8'd121;  7'd21: v = 8'd126;  7'd22: v = 8'd132;  7'd23: v = 8'd137;
			7'd24: v = 8'd142;  7'd25: v = 8'd147;  7'd26: v = 8'd152;  7'd27: v = 8'd157;
			7'd28: v = 8'd162;  7'd29: v = 8'd167;  7'd30: v = 8'd172;  7'd31: v = 8'd176;
			7'd32: v = 8'd181;  7'd33: v = 8'd185;  7'd34: v = 8'd190;  7'd35: v = 8'd194;
			7'd36: v = 8'd198;  7'd37: v = 8'd202;  7'd38: v = 8'd205;  7'd39: v = 8'd209;
			7'd40: v = 8'd213;  7'd41: v = 8'd216;  7'd42: v = 8'd219;  7'd43: v = 8'd222;
			7'd44: v = 8'd225;  7'd45: v = 8'd228;  7'd46: v = 8'd231;  7'd47: v = 8'd234;
			7'd48: v = 8'd236;  7'd49: v = 8'd238;  7'd50: v = 8'd241;  7'd51: v = 8'd243;
			7'd52: v = 8'd244;  7'd53: v = 8'd246;  7'd54: v = 8'd248;  7'd55: v = 8'd249;
			7'd56: v = 8'd250;  7'd57: v = 8'd251;  7'd58: v = 8'd252;  7'd59: v = 8'd253;
			7'd60: v = 8'd254;  7'd61: v = 8'd254;  7'd62: v = 8'd255;  7'd63: v = 8'd255;
			7'd64: v = 8'd255;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// Sine of an 8-bit angle, folded from the quarter table.
	function automatic trig_t sine8(input logic [AngW-1:0] ang);
		trig_t      r;
		logic [6:0] idx;
		if (ang[6]) begin
			idx = 7'd64 - {1'b0, ang[5:0]};
		end else begin
			idx = {1'b0, ang[5:0]};
		end
		r.neg = ang[7];
		r.mag = sine_quarter(idx);
		return r;
	endfunction

	// Quotient by 255 for values below 65280, by reciprocal with correction.
	function automatic logic [7:0] div255(input logic [ProdW-1:0] v);
		logic [ProdW-1:0] t;
		t = v + {8'd0, v[15:8]} + 16'd1;
		return t[15:8];
	endfunction

	// Apply the sign to an unsigned quotient, giving a result-width value.
	function automatic rot_t signed_term(input logic neg, input logic [7:0] q);
		rot_t r;
		r = $signed({2'b00, q});
		if (neg) begin
			r = -r;
		end
		return r;
	endfunction

endpackage

// File: design/pt_rot_if.sv
// Stream interfaces for points in and rotated points out.
// Depends on pt_rot_pkg for the field types.
`timescale 1ns / 1ps

interface pt_rot_in_if;
	logic                valid;
	logic                ready;
	pt_rot_pkg::coord_t  point_x;
	pt_rot_pkg::coord_t  point_y;
	pt_rot_pkg::time_t   time_now;

	modport source (output valid, output point_x, output point_y, output time_now, input ready);
	modport sink (input valid, input point_x, input point_y, input time_now, output ready);
endinterface

interface pt_rot_out_if;
	logic              valid;
	logic              ready;
	pt_rot_pkg::rot_t  rot_x;
	pt_rot_pkg::rot_t  rot_y;

	modport source (output valid, output rot_x, output rot_y, input ready);
	modport sink (input valid, input rot_x, input rot_y, output ready);
endinterface

// File: design/point_rotate_by_sine_table.sv
// Top level of the point rotation block: registers, angle, table and rotation pipeline.
// Depends on pt_rot_pkg, the stream interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "point_rotate_by_sine_table_defines.svh"

// Rotates each incoming point (point_x, point_y) by an angle taken from its time value.
// The time is reduced by the drag register, wrapping by one period when it would fall
// below zero, and mirrored as period minus time when reverse is set; bits 9 to 2 of that
// value form an 8-bit angle, a quarter turn being 64 steps. Sine and cosine come from a
// 65-entry quarter-wave table and span -255 to 255; each of the four products is divided
// by 255 with truncation toward zero before the terms are added, so rot_x and rot_y lie
// in -510 to 510. The block accepts one item on every clock unless a stalled result holds
// it back; each item passes through an input register, a register after the four 8 by 8
// bit multipliers and the result register. A stalled result holds the pipeline back stage by
// stage, so items already inside are kept and none is lost. Configuration writes take
// effect on the next clock and should be made while no item is in flight.
module point_rotate_by_sine_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pt_rot_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [pt_rot_pkg::CfgDataW-1:0]    cfg_data,
	pt_rot_in_if.sink                          point_ch,
	pt_rot_out_if.source                       result_ch
);
	import pt_rot_pkg::*;

	// Configuration registers.
	logic [PeriodW-1:0] period_q;
	logic [DragW-1:0]   drag_q;
	logic               reverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			drag_q    <= '0;
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD:  period_q  <= cfg_data[PeriodW-1:0];
				CFG_DRAG:    drag_q    <= cfg_data[DragW-1:0];
				CFG_REVERSE: reverse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage valids and the advance chain. A stage may load when it is empty or
	// when its contents move on in the same cycle.
	logic v_s1, v_s2, v_s3;
	logic adv_s3, adv_s2, adv_s1;

	assign adv_s3 = !v_s3 || result_ch.ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign point_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= point_ch.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: input register.
	coord_t x_s1, y_s1;
	time_t  t_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && point_ch.valid) begin
			x_s1 <= point_ch.point_x;
			y_s1 <= point_ch.point_y;
			t_s1 <= point_ch.time_now;
		end
	end

	// Angle from time. Only ten bits of time matter, since the angle is bits 9 to 2,
	// so all the wrapping arithmetic is carried out in ten bits.
	time_t          period_lo;
	time_t          drag_ext;
	time_t          adj;
	time_t          adj_dir;
	logic [AngW-1:0] ang;
	logic [AngW-1:0] ang_cos;
	trig_t          sin_v, cos_v;

	always_comb begin
		period_lo = period_q[TimeW-1:0];
		drag_ext  = {{(TimeW-DragW){1'b0}}, drag_q};
		if (t_s1 < drag_ext) begin
			adj = t_s1 + period_lo - drag_ext;
		end else begin
			adj = t_s1 - drag_ext;
		end
		if (reverse_q) begin
			adj_dir = period_lo - adj;
		end else begin
			adj_dir = adj;
		end
		ang     = adj_dir[TimeW-1:2];
		ang_cos = ang + 8'd64;
		sin_v   = sine8(ang);
		cos_v   = sine8(ang_cos);
	end

	// Stage 2: magnitudes of the four products and their signs.
	logic [ProdW-1:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic             cneg_s2, sneg_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			xc_s2   <= x_s1 * cos_v.mag;
			ys_s2   <= y_s1 * sin_v.mag;
			xs_s2   <= x_s1 * sin_v.mag;
			yc_s2   <= y_s1 * cos_v.mag;
			cneg_s2 <= cos_v.neg;
			sneg_s2 <= sin_v.neg;
		end
	end

	// Each product is at most 255 * 255, where the reciprocal form of the division
	// by 255 is exact; the sign goes on after the quotient, which truncates toward zero.
	rot_t xc_term, ys_term, xs_term, yc_term;

	always_comb begin
		xc_term = signed_term(cneg_s2, div255(xc_s2));
		ys_term = signed_term(sneg_s2, div255(ys_s2));
		xs_term = signed_term(sneg_s2, div255(xs_s2));
		yc_term = signed_term(cneg_s2, div255(yc_s2));
	end

	// Stage 3: result register.
	rot_t rx_s3, ry_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			rx_s3 <= xc_term - ys_term;
			ry_s3 <= xs_term + yc_term;
		end
	end

	assign result_ch.valid = v_s3;
	assign result_ch.rot_x = rx_s3;
	assign result_ch.rot_y = ry_s3;

	// An accepted item always sits in the input register on the next cycle.
	`PRS_ASSERT_NEXT(a_accept_loads_s1, point_ch.valid && point_ch.ready, v_s1)
	// With every stage full and the result stalled, no new item may enter.
	`PRS_ASSERT_NOW(a_full_blocks_input, v_s1 && v_s2 && v_s3 && !result_ch.ready,
		!point_ch.ready)
	// A result never leaves the range that the table and the truncation allow.
	`PRS_ASSERT_NOW(a_rot_range, result_ch.valid,
		($signed(result_ch.rot_x) >= -10'sd510) && ($signed(result_ch.rot_x) <= 10'sd510) &&
		($signed(result_ch.rot_y) >= -10'sd510) && ($signed(result_ch.rot_y) <= 10'sd510))

endmodule
